// ----- rtl/brb_pkg.sv -----
// ----------------------------------------------------------------------------
// brb_pkg
// shared constants, codes and types of the byte ring buffer unit
// ----------------------------------------------------------------------------
package brb_pkg;

    // buffer geometry
    localparam int unsigned DEPTH    = 1024;
    localparam int unsigned MAX_READ = 64;

    // field widths
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned GRANT_W = 7;

    // derived widths
    localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam int unsigned WIDE_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_SKIP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_STREAM = 1'b1
    } t_state;

endpackage

// ----- rtl/byte_ring_buffer_peek_skip_unit.sv -----
// ----------------------------------------------------------------------------
// byte_ring_buffer_peek_skip_unit
// byte ring buffer with all-or-nothing write bursts, read, peek and skip
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------
//  command   start && !busy         i_operation, i_data_in, i_burst_length,
//                                   i_first_of_burst
//  result    o_strobe (one cycle)   o_data_out, o_byte_valid, o_last_of_run,
//                                   o_status, o_granted_count
//
//  - write, skip and any refused or zero-length command: one result beat in
//    the cycle after the command is taken; busy stays low, so a new command
//    can be taken every cycle
//  - read or peek granting n bytes: busy while its n bytes stream, one store
//    read per cycle on the single read port; the command first moves the
//    state register into streaming, and each byte then passes the store's
//    read register, which it leaves together with its result beat; a new
//    command is taken in the cycle that shows the closing beat
//  - reset is synchronous on i_rst_n low: pointers, occupancy and burst
//    tracking clear; the byte store itself is not cleared and needs no sweep
//  - the receiver cannot stall: every beat is shown for exactly one cycle
//
module byte_ring_buffer_peek_skip_unit
    import brb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [DATA_W-1:0]  i_data_in,
    input  logic [LEN_W-1:0]   i_burst_length,
    input  logic               i_first_of_burst,
    output logic               o_strobe,
    output logic [DATA_W-1:0]  o_data_out,
    output logic               o_byte_valid,
    output logic               o_last_of_run,
    output logic [1:0]         o_status,
    output logic [GRANT_W-1:0] o_granted_count
);

    // control state
    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [LEN_W-1:0]   r_brem, n_brem;
    logic               r_drop, n_drop;

    // streaming state for read and peek
    logic [PTR_W-1:0]   r_addr, n_addr;
    logic [GRANT_W-1:0] r_left, n_left;
    logic [GRANT_W-1:0] r_grant, n_grant;

    // result beat registers
    logic               r_strobe, n_strobe;
    logic               r_valid, n_valid;
    logic               r_last, n_last;
    t_status            r_status, n_status;
    logic [GRANT_W-1:0] r_granted, n_granted;

    // store ports
    logic               ram_we;
    logic               ram_re;
    logic [DATA_W-1:0]  ram_q;

    // arithmetic helpers, all in one common wide width
    logic [WIDE_W-1:0]  len_w;
    logic [WIDE_W-1:0]  fill_w;
    logic [WIDE_W-1:0]  free_w;
    logic [WIDE_W-1:0]  grant_w;
    logic [WIDE_W-1:0]  adv_w;
    logic [WIDE_W-1:0]  rp_sum;
    logic               do_store;

    assign len_w  = WIDE_W'(i_burst_length);
    assign fill_w = WIDE_W'(r_fill);
    assign free_w = WIDE_W'(DEPTH) - fill_w;

    // bytes granted: request clamped to the read limit and to what is held
    always_comb begin
        grant_w = len_w;
        if (grant_w > WIDE_W'(MAX_READ)) begin
            grant_w = WIDE_W'(MAX_READ);
        end
        if (grant_w > fill_w) begin
            grant_w = fill_w;
        end
    end

    // read pointer advance: skip moves by the request, read by the grant;
    // the amount never exceeds the fill, so one wrap subtraction is enough
    assign adv_w  = (t_op'(i_operation) == OP_SKIP) ? len_w : grant_w;
    assign rp_sum = WIDE_W'(r_rp) + adv_w;

    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_brem    = r_brem;
        n_drop    = r_drop;
        n_addr    = r_addr;
        n_left    = r_left;
        n_grant   = r_grant;
        n_strobe  = 1'b0;
        n_valid   = 1'b0;
        n_last    = 1'b1;
        n_status  = ST_OK;
        n_granted = '0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        do_store  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_op'(i_operation))
                        OP_WRITE: begin
                            n_strobe = 1'b1;
                            if (i_first_of_burst) begin
                                if (i_burst_length == '0) begin
                                    // empty burst closes any open one
                                    n_brem   = '0;
                                    n_drop   = 1'b0;
                                    n_status = ST_REJECT;
                                end else if (len_w > free_w) begin
                                    // not enough room: drop the whole burst
                                    n_brem   = i_burst_length - LEN_W'(1);
                                    n_drop   = 1'b1;
                                    n_status = ST_REJECT;
                                end else begin
                                    n_brem   = i_burst_length - LEN_W'(1);
                                    n_drop   = 1'b0;
                                    do_store = 1'b1;
                                end
                            end else if (r_brem == '0) begin
                                // stray byte outside any burst
                                n_status = ST_REJECT;
                            end else begin
                                n_brem = r_brem - LEN_W'(1);
                                if (r_drop) begin
                                    n_status = ST_REJECT;
                                end else begin
                                    do_store = 1'b1;
                                end
                                if (r_brem == LEN_W'(1)) begin
                                    n_drop = 1'b0;
                                end
                            end

                            if (do_store) begin
                                if (fill_w >= WIDE_W'(DEPTH)) begin
                                    n_status = ST_REJECT;
                                end else begin
                                    ram_we = 1'b1;
                                    n_wp   = (r_wp == PTR_W'(DEPTH - 1)) ? '0
                                           : r_wp + PTR_W'(1);
                                    n_fill = r_fill + CNT_W'(1);
                                end
                            end
                        end

                        OP_SKIP: begin
                            n_strobe = 1'b1;
                            if (i_burst_length == '0) begin
                                n_status = ST_REJECT;
                            end else if (len_w > fill_w) begin
                                n_status = ST_REFUSED;
                            end else begin
                                n_rp   = (rp_sum >= WIDE_W'(DEPTH))
                                       ? PTR_W'(rp_sum - WIDE_W'(DEPTH))
                                       : PTR_W'(rp_sum);
                                n_fill = CNT_W'(fill_w - len_w);
                            end
                        end

                        OP_READ, OP_PEEK: begin
                            if (i_burst_length == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_REJECT;
                            end else if (r_fill == '0) begin
                                n_strobe = 1'b1;
                                n_status = ST_REFUSED;
                            end else begin
                                // hand over to the byte stream
                                n_state = S_STREAM;
                                n_addr  = r_rp;
                                n_left  = GRANT_W'(grant_w);
                                n_grant = GRANT_W'(grant_w);
                                if (t_op'(i_operation) == OP_READ) begin
                                    n_rp   = (rp_sum >= WIDE_W'(DEPTH))
                                           ? PTR_W'(rp_sum - WIDE_W'(DEPTH))
                                           : PTR_W'(rp_sum);
                                    n_fill = CNT_W'(fill_w - grant_w);
                                end
                            end
                        end

                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end

            S_STREAM: begin
                // one store read per cycle; the byte lands in the read
                // register together with its beat
                ram_re    = 1'b1;
                n_strobe  = 1'b1;
                n_valid   = 1'b1;
                n_last    = (r_left == GRANT_W'(1));
                n_granted = r_grant;
                n_left    = r_left - GRANT_W'(1);
                n_addr    = (r_addr == PTR_W'(DEPTH - 1)) ? '0 : r_addr + PTR_W'(1);
                if (r_left == GRANT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rp     <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_brem   <= '0;
            r_drop   <= 1'b0;
            r_strobe <= 1'b0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rp     <= n_rp;
            r_wp     <= n_wp;
            r_fill   <= n_fill;
            r_brem   <= n_brem;
            r_drop   <= n_drop;
            r_strobe <= n_strobe;
            r_valid  <= n_valid;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_left    <= n_left;
        r_grant   <= n_grant;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    brb_ram #(
        .DATA_W (DATA_W),
        .WORDS  (DEPTH),
        .ADDR_W (PTR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wp),
        .i_wdata (i_data_in),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_q)
    );

    assign busy            = (r_state == S_STREAM);
    assign o_strobe        = r_strobe;
    assign o_data_out      = r_valid ? ram_q : '0;
    assign o_byte_valid    = r_valid;
    assign o_last_of_run   = r_last;
    assign o_status        = r_status;
    assign o_granted_count = r_granted;

    // occupancy never exceeds the store size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // a streaming byte always has at least one byte left to fetch
    a_stream_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> (r_left != '0))
        else $error("stream state with nothing left");

    // a write or skip command answers in the next cycle with a final beat
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == OP_WRITE || i_operation == OP_SKIP))
        |=> (o_strobe && o_last_of_run && !o_byte_valid))
        else $error("missing single result beat");

    // when the stream ends the closing beat is on the ports
    a_stream_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_last_of_run && o_byte_valid))
        else $error("stream ended without its last beat");

    // buffered bytes only travel on a strobed beat
    a_valid_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_byte_valid |-> (o_strobe && o_granted_count != '0))
        else $error("byte beat without strobe or grant");

endmodule

// ----- rtl/brb_ram.sv -----
// ----------------------------------------------------------------------------
// brb_ram
// simple dual-port byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module brb_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned WORDS  = 1024,
    parameter int unsigned ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [WORDS];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
